// File: rtl/core/matrix_multiply_unit_defines.svh
// ----------------------------------------------------------------------------
// Matrix multiply unit assertion macros
// Shared property forms for the checker of the matrix multiply unit.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MMU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mmu_pkg.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit package
// Sizes, command codes, register indexes and shared types.
// ----------------------------------------------------------------------------
package mmu_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int FUNC_W      = 2;
    localparam int DATA_W      = 16;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int RES_W       = 35;
    localparam int CFG_IDX_W   = 2;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_LEFT  = 2'd0,
        FUNC_LOAD_RIGHT = 2'd1,
        FUNC_MULTIPLY   = 2'd2,
        FUNC_NOP        = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_LEFT  = 2'd0,
        CFG_INNER_SIZE = 2'd1,
        CFG_COLS_RIGHT = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             vld;
        logic             first;
        logic             lastk;
        logic             zero;
        logic             lastel;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_mac_ctl;

    function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] reg_val);
        dim_limit = (reg_val > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : reg_val;
    endfunction

endpackage

// File: rtl/core/matrix_multiply_unit.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit
// Loads Q8.8 left/right matrices into two synchronous stores and emits the
// product in row-major order with one multiply-accumulate per cycle.
// ----------------------------------------------------------------------------
// Load: each accepted start writes one item; busy stays low.
// Multiply: rows*cols*max(inner,1) MACs, one MAC per cycle set by the
//   single read port of each store; results pass s1, s2 and the output regs.
// Results appear for one cycle on o_valid; the receiver cannot stall.
// Synchronous active-low reset clears control and sets each size register to 8;
//   store contents stay undefined until written.
module matrix_multiply_unit
    import mmu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [IDX_W-1:0]     i_row,
    input  logic [IDX_W-1:0]     i_col,
    input  logic signed [DATA_W-1:0] i_value,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DIM_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [IDX_W-1:0]     o_row_res,
    output logic [IDX_W-1:0]     o_col_res,
    output logic signed [RES_W-1:0] o_value_res,
    output logic                 o_last
);

    logic signed [DATA_W-1:0] mem_left  [STORE_DEPTH];
    logic signed [DATA_W-1:0] mem_right [STORE_DEPTH];

    logic [DIM_W-1:0] r_rows_left, r_inner_size, r_cols_right;
    logic [DIM_W-1:0] r_nr, r_nk, r_nc;
    logic             r_zero;
    logic             r_run;
    logic [IDX_W-1:0] r_i, r_j, r_k;

    logic signed [DATA_W-1:0] r_left_q, r_right_q;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RES_W-1:0]  r_acc;
    t_mac_ctl                 r_s1, r_s2;

    logic                     accept;
    logic [ADDR_W-1:0]        wr_addr, rd_left_addr, rd_right_addr;
    logic                     lastk, lastj, lasti;
    logic [DIM_W-1:0]         lim_nr, lim_nk, lim_nc;
    logic signed [RES_W-1:0]  n_acc;

    assign busy   = r_run | r_s1.vld | r_s2.vld;
    assign accept = start & ~busy;

    assign wr_addr       = ADDR_W'(int'(i_row) * MAX_DIM + int'(i_col));
    assign rd_left_addr  = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_k));
    assign rd_right_addr = ADDR_W'(int'(r_k) * MAX_DIM + int'(r_j));

    assign lim_nr = dim_limit(r_rows_left);
    assign lim_nk = dim_limit(r_inner_size);
    assign lim_nc = dim_limit(r_cols_right);

    assign lastk = (r_zero || ({1'b0, r_k} + DIM_W'(1)) == r_nk);
    assign lastj = (({1'b0, r_j} + DIM_W'(1)) == r_nc);
    assign lasti = (({1'b0, r_i} + DIM_W'(1)) == r_nr);

    assign n_acc = (r_s2.first ? RES_W'(0) : r_acc) + RES_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (accept && t_func'(i_func) == FUNC_LOAD_LEFT) begin
            mem_left[wr_addr] <= i_value;
        end
        if (accept && t_func'(i_func) == FUNC_LOAD_RIGHT) begin
            mem_right[wr_addr] <= i_value;
        end
        r_left_q  <= mem_left[rd_left_addr];
        r_right_q <= mem_right[rd_right_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_left  <= DIM_RESET;
            r_inner_size <= DIM_RESET;
            r_cols_right <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROWS_LEFT:  r_rows_left  <= i_cfg_data;
                CFG_INNER_SIZE: r_inner_size <= i_cfg_data;
                CFG_COLS_RIGHT: r_cols_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (accept && t_func'(i_func) == FUNC_MULTIPLY) begin
            r_run <= (lim_nr != '0) && (lim_nc != '0);
        end else if (r_run && lastk && lastj && lasti) begin
            r_run <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_func'(i_func) == FUNC_MULTIPLY) begin
            r_nr   <= lim_nr;
            r_nk   <= lim_nk;
            r_nc   <= lim_nc;
            r_zero <= (lim_nk == '0);
            r_i    <= '0;
            r_j    <= '0;
            r_k    <= '0;
        end else if (r_run) begin
            if (lastk) begin
                r_k <= '0;
                if (lastj) begin
                    r_j <= '0;
                    r_i <= r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end else begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
        end else begin
            r_s1.vld <= r_run;
            r_s2.vld <= r_s1.vld;
        end
        r_s1.first  <= (r_k == '0);
        r_s1.lastk  <= lastk;
        r_s1.zero   <= r_zero;
        r_s1.lastel <= lastj && lasti;
        r_s1.i      <= r_i;
        r_s1.j      <= r_j;
        r_s2.first  <= r_s1.first;
        r_s2.lastk  <= r_s1.lastk;
        r_s2.zero   <= r_s1.zero;
        r_s2.lastel <= r_s1.lastel;
        r_s2.i      <= r_s1.i;
        r_s2.j      <= r_s1.j;
        r_prod      <= r_s1.zero ? PROD_W'(0) : r_left_q * r_right_q;
        if (r_s2.vld) begin
            r_acc <= n_acc;
        end
        if (r_s2.vld && r_s2.lastk) begin
            o_value_res <= n_acc;
            o_row_res   <= r_s2.i;
            o_col_res   <= r_s2.j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_last  <= 1'b0;
        end else begin
            o_valid <= r_s2.vld && r_s2.lastk;
            o_last  <= r_s2.vld && r_s2.lastk && r_s2.lastel;
        end
    end

endmodule

// File: rtl/core/mmu_checker.sv
// ----------------------------------------------------------------------------
// Matrix multiply unit checker
// Port-level properties of the result strobe against busy.
// ----------------------------------------------------------------------------
`include "matrix_multiply_unit_defines.svh"

module mmu_checker
    import mmu_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic busy,
    input logic o_valid,
    input logic o_last
);

    `MMU_ASSERT_NOW(a_last_has_valid, i_clk, i_rst_n, o_last, o_valid, "last without transfer")
    `MMU_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_last, !busy, "busy after final transfer")
    `MMU_ASSERT_NOW(a_more_busy, i_clk, i_rst_n, o_valid && !o_last, busy, "run ended early")
    `MMU_ASSERT_NEXT(a_valid_from_busy, i_clk, i_rst_n, !busy, !o_valid, "transfer without run")

endmodule

bind matrix_multiply_unit mmu_checker u_mmu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_valid (o_valid),
    .o_last  (o_last)
);
